// ----- src/dwf_pkg.sv -----
`default_nettype none

package dwf_pkg;

	localparam int KERNEL_SIZE   = 5;
	localparam int DEF_MAX_WIDTH = 1024;

	localparam int PIX_W       = 8;
	localparam int TERM_W      = 5;
	localparam int ROW_W       = 16;
	localparam int COL_OUT_W   = 10;
	localparam int CFG_WIDTH_W = 11;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CFG_WIDTH_W-1:0] RST_FRAME_WIDTH  = 11'd1024;
	localparam logic [ROW_W-1:0]       RST_FRAME_HEIGHT = 16'd1024;
	localparam logic                   RST_WEIGHT_SIGN  = 1'b0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH  = 2'd0,
		CFG_FRAME_HEIGHT = 2'd1,
		CFG_WEIGHT_SIGN  = 2'd2
	} cfg_idx_t;

	typedef logic [PIX_W-1:0]  pix_t;
	typedef logic [TERM_W-1:0] term_t;

	// exact for every 8-bit value: floor(x * 205 / 2048) == floor(x / 10)
	function automatic term_t div10(pix_t x);
		logic [15:0] p;
		p = 16'(x) * 16'd205;
		return term_t'(p >> 11);
	endfunction

	// k: rows back from the newest, d: words back within the row
	function automatic logic in_diamond(int k, int d);
		int ak;
		int ad;
		ak = (k > 2) ? k - 2 : 2 - k;
		ad = (d > 2) ? d - 2 : 2 - d;
		return (ak + ad) <= 2;
	endfunction

endpackage

`default_nettype wire

// ----- src/dwf_cell.sv -----
`default_nettype none

module dwf_cell #(
	parameter int MAX_WIDTH = dwf_pkg::DEF_MAX_WIDTH
) (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire logic [$clog2(MAX_WIDTH)-1:0] ptr,
	input  wire dwf_pkg::pix_t                din,
	output      dwf_pkg::pix_t [4:0]          taps
);

	dwf_pkg::pix_t mem [MAX_WIDTH];
	dwf_pkg::pix_t [4:0] sr_q;

	always_ff @(posedge clk) begin
		if (en) begin
			mem[ptr] <= din;
			sr_q     <= {sr_q[3:0], mem[ptr]};
		end
	end

	assign taps = sr_q;

endmodule

`default_nettype wire

// ----- src/diamond_window_filter_5x5.sv -----
`default_nettype none

// channel  dir  width  contents (low bit first)
// s_*      in   8+1    tdata: pixel; tuser: is_pad
// m_*      out  40+1   tdata: value, out_row, out_col, zero fill; tlast: frame_end
// cfg_*    in   2+16   index 0 frame_width, 1 frame_height, 2 weight_sign
//
// One word per clock in steady state while m_tready holds: each of the four line cells
// does one memory write and one registered read per accepted word.
// A result passes the stage-1 window taps, the stage-2 partial sums and the output register
// after the word that completes its window, which is 2*width+2 words after its centre pixel.
// Stalls on m_* back up through two stages before s_tready drops.
// Reset clears counters and valid flags and loads the configuration defaults; line memories need no clearing.

module diamond_window_filter_5x5 #(
	parameter int MAX_WIDTH = dwf_pkg::DEF_MAX_WIDTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output      logic                            s_tready,
	input  wire logic [7:0]                      s_tdata,   // pixel
	input  wire logic                            s_tuser,   // is_pad
	output      logic                            m_tvalid,
	input  wire logic                            m_tready,
	output      logic [39:0]                     m_tdata,   // value, out_row, out_col
	output      logic                            m_tlast,   // frame_end
	input  wire logic                            cfg_we,
	input  wire logic [dwf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [dwf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int EW = (WW > dwf_pkg::CFG_WIDTH_W) ? WW : dwf_pkg::CFG_WIDTH_W;
	localparam int RW = dwf_pkg::ROW_W;

	logic [dwf_pkg::CFG_WIDTH_W-1:0] width_q;
	logic [RW-1:0]                   height_q;
	logic                            sign_q;

	logic [EW-1:0] fw_e;
	logic [EW-1:0] w_e;
	logic [WW-1:0] w;
	logic [RW-1:0] h;

	logic [CW-1:0] in_col_q;
	logic [RW-1:0] in_row_q;
	logic [CW-1:0] emit_col_q;
	logic [RW-1:0] emit_row_q;
	logic [CW-1:0] ptr_q;

	logic          acc;
	logic          adv1;
	logic          adv2;
	logic          rdy_c;
	logic          last_c;
	logic [CW-1:0] ec;
	logic [WW-1:0] in_col_inc;
	logic [WW-1:0] ec_inc;
	logic [4:0]    rowm_c;
	logic [4:0]    colm_c;
	dwf_pkg::pix_t pix_in;

	dwf_pkg::pix_t [2:0] row0_q;
	dwf_pkg::pix_t [4:0] cell_taps [1:4];
	dwf_pkg::pix_t [4:0] tap_c [5];
	logic [8:0]          part_c [5];

	logic          valid_s1;
	logic [RW-1:0] row_s1;
	logic [CW-1:0] col_s1;
	logic          last_s1;
	logic          sign_s1;
	logic [4:0]    rowm_s1;
	logic [4:0]    colm_s1;

	logic          valid_s2;
	logic [8:0]    part_s2 [5];
	logic [RW-1:0] row_s2;
	logic [CW-1:0] col_s2;
	logic          last_s2;
	logic          sign_s2;

	logic [8:0]    total_c;
	logic [7:0]    value_c;

	logic                            out_valid_q;
	logic [7:0]                      value_q;
	logic [RW-1:0]                   out_row_q;
	logic [dwf_pkg::COL_OUT_W-1:0]   out_col_q;
	logic                            frame_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= dwf_pkg::RST_FRAME_WIDTH;
			height_q <= dwf_pkg::RST_FRAME_HEIGHT;
			sign_q   <= dwf_pkg::RST_WEIGHT_SIGN;
		end else if (cfg_we) begin
			case (cfg_index)
				dwf_pkg::CFG_FRAME_WIDTH:  width_q  <= cfg_wdata[dwf_pkg::CFG_WIDTH_W-1:0];
				dwf_pkg::CFG_FRAME_HEIGHT: height_q <= cfg_wdata[RW-1:0];
				dwf_pkg::CFG_WEIGHT_SIGN:  sign_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		fw_e = EW'(width_q);
		if (fw_e < EW'(dwf_pkg::KERNEL_SIZE))
			w_e = EW'(dwf_pkg::KERNEL_SIZE);
		else if (fw_e > EW'(MAX_WIDTH))
			w_e = EW'(MAX_WIDTH);
		else
			w_e = fw_e;
		w = WW'(w_e);
		h = (height_q < RW'(dwf_pkg::KERNEL_SIZE)) ? RW'(dwf_pkg::KERNEL_SIZE) : height_q;
	end

	assign adv2     = !out_valid_q || m_tready;
	assign adv1     = !valid_s2 || adv2;
	assign s_tready = !valid_s1 || adv1;
	assign acc      = s_tvalid && s_tready;
	assign pix_in   = s_tuser ? '0 : s_tdata;

	always_comb begin
		rdy_c      = (in_row_q > RW'(2)) || (in_row_q == RW'(2) && in_col_q >= CW'(2));
		in_col_inc = WW'(in_col_q) + WW'(1);
		ec         = (WW'(emit_col_q) >= w) ? '0 : emit_col_q;
		ec_inc     = WW'(ec) + WW'(1);
		last_c     = (emit_row_q >= h - RW'(1)) && (WW'(ec) >= w - WW'(1));
		rowm_c[0]  = emit_row_q < h - RW'(2);
		rowm_c[1]  = emit_row_q < h - RW'(1);
		rowm_c[2]  = emit_row_q < h;
		rowm_c[3]  = (emit_row_q != '0) && (emit_row_q - RW'(1) < h);
		rowm_c[4]  = (emit_row_q >= RW'(2)) && (emit_row_q - RW'(2) < h);
		colm_c[0]  = WW'(ec) < w - WW'(2);
		colm_c[1]  = WW'(ec) < w - WW'(1);
		colm_c[2]  = 1'b1;
		colm_c[3]  = ec != '0;
		colm_c[4]  = ec >= CW'(2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			emit_col_q <= '0;
			emit_row_q <= '0;
			ptr_q      <= '0;
		end else if (acc) begin
			ptr_q <= (WW'(ptr_q) >= w - WW'(2)) ? '0 : ptr_q + CW'(1);
			if (rdy_c && last_c) begin
				in_col_q   <= '0;
				in_row_q   <= '0;
				emit_col_q <= '0;
				emit_row_q <= '0;
			end else begin
				if (in_col_inc >= w) begin
					in_col_q <= '0;
					if (in_row_q != '1)
						in_row_q <= in_row_q + RW'(1);
				end else begin
					in_col_q <= CW'(in_col_inc);
				end
				if (rdy_c) begin
					if (ec_inc >= w) begin
						emit_col_q <= '0;
						emit_row_q <= emit_row_q + RW'(1);
					end else begin
						emit_col_q <= CW'(ec_inc);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc)
			row0_q <= {row0_q[1:0], pix_in};
	end

	for (genvar k = 1; k <= 4; k++) begin : g_cell
		dwf_cell #(
			.MAX_WIDTH (MAX_WIDTH)
		) u_cell (
			.clk  (clk),
			.en   (acc),
			.ptr  (ptr_q),
			.din  ((k == 1) ? row0_q[0] : cell_taps[(k == 1) ? 1 : k - 1][0]),
			.taps (cell_taps[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= rdy_c;
		end else if (adv1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && rdy_c) begin
			row_s1  <= emit_row_q;
			col_s1  <= ec;
			last_s1 <= last_c;
			sign_s1 <= sign_q;
			rowm_s1 <= rowm_c;
			colm_s1 <= colm_c;
		end
	end

	always_comb begin
		tap_c[0] = {16'h0000, row0_q};
		for (int k = 1; k <= 4; k++)
			tap_c[k] = cell_taps[k];
		for (int k = 0; k < 5; k++) begin
			part_c[k] = '0;
			for (int d = 0; d < 5; d++) begin
				if (dwf_pkg::in_diamond(k, d) && rowm_s1[k] && colm_s1[d])
					part_c[k] = part_c[k] + 9'(dwf_pkg::div10(tap_c[k][d]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && valid_s1) begin
			part_s2 <= part_c;
			row_s2  <= row_s1;
			col_s2  <= col_s1;
			last_s2 <= last_s1;
			sign_s2 <= sign_s1;
		end
	end

	always_comb begin
		total_c = part_s2[0] + part_s2[1] + part_s2[2] + part_s2[3] + part_s2[4];
		if (sign_s2)
			value_c = '0;
		else if (total_c > 9'd255)
			value_c = 8'd255;
		else
			value_c = total_c[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv2) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && valid_s2) begin
			value_q     <= value_c;
			out_row_q   <= row_s2;
			out_col_q   <= dwf_pkg::COL_OUT_W'(col_s2);
			frame_end_q <= last_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b000000, out_col_q, out_row_q, value_q};
	assign m_tlast  = frame_end_q;

	a_hold_taps: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv1) |-> !s_tready)
		else $error("window taps would shift under a held stage-1 word");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && rdy_c && last_c) |=>
		(in_row_q == '0 && in_col_q == '0 && emit_row_q == '0 && emit_col_q == '0))
		else $error("position counters not cleared after frame end");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		WW'(ptr_q) <= WW'(MAX_WIDTH - 2))
		else $error("line pointer beyond line memory");

	a_neg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(adv2 && valid_s2 && sign_s2) |=> (m_tdata[7:0] == '0))
		else $error("minus-one weights gave a nonzero word");

endmodule

`default_nettype wire
